>>> hw/rtl/jsu_pkg.sv
// jsu_pkg: shared types, character codes and helpers for the json string unescaper
// used by jsu_decoder, jsu_serializer and json_string_unescaper_top; no dependencies
package jsu_pkg;

	typedef enum logic [1:0] {
		MODE_WAIT = 2'd0,
		MODE_TEXT = 2'd1,
		MODE_ESC  = 2'd2,
		MODE_HEX  = 2'd3
	} mode_t;

	typedef enum logic [2:0] {
		ST_DATA    = 3'd0,
		ST_DONE    = 3'd1,
		ST_NOQUOTE = 3'd2,
		ST_CTRL    = 3'd3,
		ST_BADESC  = 3'd4,
		ST_BADHEX  = 3'd5,
		ST_UNTERM  = 3'd6
	} status_t;

	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_SLASH  = 8'h2F;
	localparam logic [7:0] CH_B      = 8'h62;
	localparam logic [7:0] CH_F      = 8'h66;
	localparam logic [7:0] CH_N      = 8'h6E;
	localparam logic [7:0] CH_R      = 8'h72;
	localparam logic [7:0] CH_T      = 8'h74;
	localparam logic [7:0] CH_U      = 8'h75;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_NUL    = 8'h00;
	localparam logic [7:0] CH_BS     = 8'h08;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_FF     = 8'h0C;
	localparam logic [7:0] CH_CR     = 8'h0D;

	// results caused by one input word, up to three
	typedef struct packed {
		logic [1:0] n;
		logic [7:0] b0;
		logic [7:0] b1;
		logic [7:0] b2;
		status_t    status;
	} group_t;

	// {valid, nibble} for an ascii hex digit
	function automatic logic [4:0] hex_nibble(input logic [7:0] b);
		logic [7:0] t;
		logic [4:0] r;
		r = 5'd0;
		if (b >= CH_ZERO && b <= 8'h39) begin
			t = b - CH_ZERO;
			r = {1'b1, t[3:0]};
		end else if (b >= 8'h61 && b <= CH_F) begin
			t = b - 8'h57;
			r = {1'b1, t[3:0]};
		end else if (b >= 8'h41 && b <= 8'h46) begin
			t = b - 8'h37;
			r = {1'b1, t[3:0]};
		end
		return r;
	endfunction

endpackage

>>> hw/rtl/jsu_decoder.sv
// jsu_decoder: parse state and per-word decode into a result group
// depends on jsu_pkg
module jsu_decoder (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           advance,
	input  logic [7:0]     byte_s1,
	output jsu_pkg::group_t grp
);

	jsu_pkg::mode_t mode_q, mode_d;
	logic [1:0]     cnt_q, cnt_d;
	logic [15:0]    cp_q, cp_d;
	logic [4:0]     hx;
	logic [15:0]    cp_new;

	assign hx     = jsu_pkg::hex_nibble(byte_s1);
	assign cp_new = {cp_q[11:0], hx[3:0]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= jsu_pkg::MODE_WAIT;
			cnt_q  <= 2'd0;
			cp_q   <= 16'd0;
		end else if (advance) begin
			mode_q <= mode_d;
			cnt_q  <= cnt_d;
			cp_q   <= cp_d;
		end
	end

	// next state
	always_comb begin
		mode_d = jsu_pkg::MODE_WAIT;
		cnt_d  = 2'd0;
		cp_d   = 16'd0;
		unique case (mode_q)
			jsu_pkg::MODE_WAIT: begin
				if (byte_s1 == jsu_pkg::CH_QUOTE) mode_d = jsu_pkg::MODE_TEXT;
			end
			jsu_pkg::MODE_TEXT: begin
				if (byte_s1 == jsu_pkg::CH_BSLASH) mode_d = jsu_pkg::MODE_ESC;
				else if (byte_s1 == jsu_pkg::CH_QUOTE || byte_s1 == jsu_pkg::CH_NUL
					|| byte_s1 == jsu_pkg::CH_LF || byte_s1 == jsu_pkg::CH_CR
					|| byte_s1 == jsu_pkg::CH_TAB || byte_s1 == jsu_pkg::CH_BS
					|| byte_s1 == jsu_pkg::CH_FF) mode_d = jsu_pkg::MODE_WAIT;
				else mode_d = jsu_pkg::MODE_TEXT;
			end
			jsu_pkg::MODE_ESC: begin
				priority case (byte_s1)
					jsu_pkg::CH_QUOTE, jsu_pkg::CH_BSLASH, jsu_pkg::CH_SLASH,
					jsu_pkg::CH_B, jsu_pkg::CH_F, jsu_pkg::CH_N,
					jsu_pkg::CH_R, jsu_pkg::CH_T: mode_d = jsu_pkg::MODE_TEXT;
					jsu_pkg::CH_U:                mode_d = jsu_pkg::MODE_HEX;
					default:                      mode_d = jsu_pkg::MODE_WAIT;
				endcase
			end
			jsu_pkg::MODE_HEX: begin
				if (byte_s1 != jsu_pkg::CH_NUL && hx[4]) begin
					if (cnt_q == 2'd3) begin
						mode_d = jsu_pkg::MODE_TEXT;
					end else begin
						mode_d = jsu_pkg::MODE_HEX;
						cnt_d  = cnt_q + 2'd1;
						cp_d   = cp_new;
					end
				end
			end
			default: mode_d = jsu_pkg::MODE_WAIT;
		endcase
	end

	// result group for this word
	always_comb begin
		grp        = '0;
		grp.status = jsu_pkg::ST_DATA;
		unique case (mode_q)
			jsu_pkg::MODE_WAIT: begin
				if (byte_s1 != jsu_pkg::CH_QUOTE) begin
					grp.n      = 2'd1;
					grp.status = jsu_pkg::ST_NOQUOTE;
				end
			end
			jsu_pkg::MODE_TEXT: begin
				grp.n = 2'd1;
				if (byte_s1 == jsu_pkg::CH_QUOTE) grp.status = jsu_pkg::ST_DONE;
				else if (byte_s1 == jsu_pkg::CH_NUL) grp.status = jsu_pkg::ST_UNTERM;
				else if (byte_s1 == jsu_pkg::CH_LF || byte_s1 == jsu_pkg::CH_CR
					|| byte_s1 == jsu_pkg::CH_TAB || byte_s1 == jsu_pkg::CH_BS
					|| byte_s1 == jsu_pkg::CH_FF) grp.status = jsu_pkg::ST_CTRL;
				else if (byte_s1 == jsu_pkg::CH_BSLASH) grp.n = 2'd0;
				else grp.b0 = byte_s1;
			end
			jsu_pkg::MODE_ESC: begin
				grp.n = 2'd1;
				priority case (byte_s1)
					jsu_pkg::CH_QUOTE, jsu_pkg::CH_BSLASH,
					jsu_pkg::CH_SLASH: grp.b0 = byte_s1;
					jsu_pkg::CH_B:     grp.b0 = jsu_pkg::CH_BS;
					jsu_pkg::CH_F:     grp.b0 = jsu_pkg::CH_FF;
					jsu_pkg::CH_N:     grp.b0 = jsu_pkg::CH_LF;
					jsu_pkg::CH_R:     grp.b0 = jsu_pkg::CH_CR;
					jsu_pkg::CH_T:     grp.b0 = jsu_pkg::CH_TAB;
					jsu_pkg::CH_U:     grp.n = 2'd0;
					jsu_pkg::CH_NUL:   grp.status = jsu_pkg::ST_UNTERM;
					default:           grp.status = jsu_pkg::ST_BADESC;
				endcase
			end
			jsu_pkg::MODE_HEX: begin
				if (byte_s1 == jsu_pkg::CH_NUL) begin
					grp.n      = 2'd1;
					grp.status = jsu_pkg::ST_UNTERM;
				end else if (!hx[4]) begin
					grp.n      = 2'd1;
					grp.status = jsu_pkg::ST_BADHEX;
				end else if (cnt_q == 2'd3) begin
					// utf-8 encode of the finished code point
					if (cp_new < 16'h0080) begin
						grp.n  = 2'd1;
						grp.b0 = cp_new[7:0];
					end else if (cp_new < 16'h0800) begin
						grp.n  = 2'd2;
						grp.b0 = {3'b110, cp_new[10:6]};
						grp.b1 = {2'b10, cp_new[5:0]};
					end else begin
						grp.n  = 2'd3;
						grp.b0 = {4'b1110, cp_new[15:12]};
						grp.b1 = {2'b10, cp_new[11:6]};
						grp.b2 = {2'b10, cp_new[5:0]};
					end
				end
			end
			default: grp.n = 2'd0;
		endcase
	end

	a_cnt_only_hex: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q != 2'd0 |-> mode_q == jsu_pkg::MODE_HEX)
		else $error("digit count set outside hex mode");

	a_cp_only_hex: assert property (@(posedge clk) disable iff (!arst_n)
		mode_q != jsu_pkg::MODE_HEX |-> cp_q == 16'd0)
		else $error("code point left over outside hex mode");

	a_group_size: assert property (@(posedge clk) disable iff (!arst_n)
		grp.n == 2'd3 |-> mode_q == jsu_pkg::MODE_HEX && cnt_q == 2'd3)
		else $error("three-byte group outside final hex digit");

endmodule

>>> hw/rtl/jsu_serializer.sv
// jsu_serializer: result buffer that sends a group out one word per cycle while out_stall is low
// depends on jsu_pkg
module jsu_serializer (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            load,
	input  jsu_pkg::group_t grp,
	input  logic            out_stall,
	output logic            free,
	output logic            out_valid,
	output logic [7:0]      out_byte,
	output logic [2:0]      status,
	output logic            last_of_run
);

	logic [1:0]      n_q;
	logic [7:0]      b0_q, b1_q, b2_q;
	jsu_pkg::status_t st_q;
	logic            take;

	assign out_valid   = n_q != 2'd0;
	assign take        = out_valid && !out_stall;
	assign free        = (n_q == 2'd0) || (n_q == 2'd1 && take);
	assign out_byte    = b0_q;
	assign status      = st_q;
	assign last_of_run = n_q == 2'd1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_q <= 2'd0;
		end else if (load) begin
			n_q <= grp.n;
		end else if (take) begin
			n_q <= n_q - 2'd1;
		end
	end

	// payload shifts toward b0 as words leave
	always_ff @(posedge clk) begin
		if (load) begin
			b0_q <= grp.b0;
			b1_q <= grp.b1;
			b2_q <= grp.b2;
			st_q <= grp.status;
		end else if (take) begin
			b0_q <= b1_q;
			b1_q <= b2_q;
		end
	end

	a_load_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		load |-> free)
		else $error("group loaded over pending words");

	a_error_single: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != jsu_pkg::ST_DATA |-> last_of_run && out_byte == 8'd0)
		else $error("status word not alone or not zero");

endmodule

>>> hw/rtl/json_string_unescaper_top.sv
// json_string_unescaper_top: streaming json string literal decoder
// depends on jsu_pkg, jsu_decoder, jsu_serializer
//
//  channel | direction | handshake           | payload
//  in      | sink      | in_valid / in_stall | in_byte
//  out     | source    | out_valid/out_stall | out_byte, status, last_of_run
//
// one input word per cycle while in_stall is low; a word waits in the input register, and
// its results (zero to three) go to the output buffer in the same edge that it leaves it
// a \uXXXX escape that encodes to two or three utf-8 bytes can stall the next word that has
// results, since the output buffer drains one word per cycle while out_stall is low
// reset clears parse state and both valid flags; no clearing pass
// in_stall follows out_stall combinationally through the buffer's free signal
module json_string_unescaper_top (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] in_byte,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] out_byte,
	output logic [2:0] status,
	output logic       last_of_run
);

	logic            valid_s1;
	logic [7:0]      byte_s1;
	logic            advance;
	logic            free;
	jsu_pkg::group_t grp;

	// a word with no results never waits on the buffer
	assign advance  = valid_s1 && (grp.n == 2'd0 || free);
	assign in_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			byte_s1 <= in_byte;
		end
	end

	jsu_decoder u_dec (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.byte_s1 (byte_s1),
		.grp     (grp)
	);

	jsu_serializer u_ser (
		.clk         (clk),
		.arst_n      (arst_n),
		.load        (advance && grp.n != 2'd0),
		.grp         (grp),
		.out_stall   (out_stall),
		.free        (free),
		.out_valid   (out_valid),
		.out_byte    (out_byte),
		.status      (status),
		.last_of_run (last_of_run)
	);

endmodule

>>> tb/tb_json_string_unescaper_top.sv
// tb_json_string_unescaper_top: self-checking bench for the streaming json string decoder
// drives byte words, predicts status / utf-8 output words in-bench, checks them in order
// depends on jsu_pkg and json_string_unescaper_top
`timescale 1ns / 1ps

module tb_json_string_unescaper_top;

	localparam int LIMIT_CYCLES = 200000;
	localparam int DRAIN_CYCLES = 20;
	localparam int RAND_PER_PHASE = 52;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_LOW_A = 8'h61;
	localparam logic [7:0] CH_UP_A  = 8'h41;
	localparam logic [7:0] CH_TILDE = 8'h7E;
	localparam logic [7:0] CH_SPACE = 8'h20;

	typedef struct packed {
		logic [7:0]       data;
		jsu_pkg::status_t st;
		logic             last;
	} out_word_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_stall;
	logic [7:0] in_byte = 8'h00;
	logic       out_valid;
	logic       out_stall = 1'b0;
	logic [7:0] out_byte;
	logic [2:0] status;
	logic       last_of_run;

	logic [7:0] text_q[$];
	out_word_t  decoded_q[$];
	int         in_idle_pct = 0;
	int         out_stall_pct = 0;
	int         errors = 0;
	int         cycles = 0;

	// decoder state as the bench sees it
	jsu_pkg::mode_t dec_mode = jsu_pkg::MODE_WAIT;
	logic [1:0]     dec_digits = 2'd0;
	logic [15:0]    dec_cp = 16'h0000;

	json_string_unescaper_top uut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.in_byte     (in_byte),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.out_byte    (out_byte),
		.status      (status),
		.last_of_run (last_of_run)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic bit roll(input int pct);
		return $urandom_range(99) < pct;
	endfunction

	function automatic bit is_raw_ctrl(input logic [7:0] b);
		return b == jsu_pkg::CH_LF || b == jsu_pkg::CH_CR || b == jsu_pkg::CH_TAB
			|| b == jsu_pkg::CH_BS || b == jsu_pkg::CH_FF;
	endfunction

	function automatic int hex_val(input logic [7:0] b);
		if (b >= jsu_pkg::CH_ZERO && b <= CH_NINE) return int'(b - jsu_pkg::CH_ZERO);
		if (b >= CH_LOW_A && b <= jsu_pkg::CH_F) return int'(b - CH_LOW_A) + 10;
		if (b >= CH_UP_A && b <= 8'h46) return int'(b - CH_UP_A) + 10;
		return -1;
	endfunction

	function automatic logic [7:0] esc_letter(input int i);
		case (i)
			0: return jsu_pkg::CH_QUOTE;
			1: return jsu_pkg::CH_BSLASH;
			2: return jsu_pkg::CH_SLASH;
			3: return jsu_pkg::CH_B;
			4: return jsu_pkg::CH_F;
			5: return jsu_pkg::CH_N;
			6: return jsu_pkg::CH_R;
			default: return jsu_pkg::CH_T;
		endcase
	endfunction

	function automatic logic [7:0] hex_char(input logic [3:0] n);
		if (n < 4'd10) return jsu_pkg::CH_ZERO + 8'(n);
		return (roll(50) ? CH_LOW_A : CH_UP_A) + 8'(n - 4'd10);
	endfunction

	task automatic push_word(input logic [7:0] d, input jsu_pkg::status_t s, input logic last);
		out_word_t w;
		w.data = d;
		w.st = s;
		w.last = last;
		decoded_q.push_back(w);
	endtask

	task automatic end_string(input jsu_pkg::status_t s);
		dec_mode = jsu_pkg::MODE_WAIT;
		dec_digits = 2'd0;
		dec_cp = 16'h0000;
		push_word(8'h00, s, 1'b1);
	endtask

	task automatic predict_unescape(input logic [7:0] b);
		int          d;
		logic [15:0] cp;
		case (dec_mode)
			jsu_pkg::MODE_WAIT: begin
				if (b == jsu_pkg::CH_QUOTE) dec_mode = jsu_pkg::MODE_TEXT;
				else end_string(jsu_pkg::ST_NOQUOTE);
			end
			jsu_pkg::MODE_TEXT: begin
				if (b == jsu_pkg::CH_QUOTE) end_string(jsu_pkg::ST_DONE);
				else if (b == jsu_pkg::CH_NUL) end_string(jsu_pkg::ST_UNTERM);
				else if (is_raw_ctrl(b)) end_string(jsu_pkg::ST_CTRL);
				else if (b == jsu_pkg::CH_BSLASH) dec_mode = jsu_pkg::MODE_ESC;
				else push_word(b, jsu_pkg::ST_DATA, 1'b1);
			end
			jsu_pkg::MODE_ESC: begin
				dec_mode = jsu_pkg::MODE_TEXT;
				case (b)
					jsu_pkg::CH_QUOTE, jsu_pkg::CH_BSLASH, jsu_pkg::CH_SLASH:
						push_word(b, jsu_pkg::ST_DATA, 1'b1);
					jsu_pkg::CH_B: push_word(jsu_pkg::CH_BS, jsu_pkg::ST_DATA, 1'b1);
					jsu_pkg::CH_F: push_word(jsu_pkg::CH_FF, jsu_pkg::ST_DATA, 1'b1);
					jsu_pkg::CH_N: push_word(jsu_pkg::CH_LF, jsu_pkg::ST_DATA, 1'b1);
					jsu_pkg::CH_R: push_word(jsu_pkg::CH_CR, jsu_pkg::ST_DATA, 1'b1);
					jsu_pkg::CH_T: push_word(jsu_pkg::CH_TAB, jsu_pkg::ST_DATA, 1'b1);
					jsu_pkg::CH_U: begin
						dec_mode = jsu_pkg::MODE_HEX;
						dec_digits = 2'd0;
						dec_cp = 16'h0000;
					end
					jsu_pkg::CH_NUL: end_string(jsu_pkg::ST_UNTERM);
					default: end_string(jsu_pkg::ST_BADESC);
				endcase
			end
			default: begin
				d = hex_val(b);
				if (b == jsu_pkg::CH_NUL) end_string(jsu_pkg::ST_UNTERM);
				else if (d < 0) end_string(jsu_pkg::ST_BADHEX);
				else begin
					cp = {dec_cp[11:0], 4'(d)};
					if (dec_digits != 2'd3) begin
						dec_digits = dec_digits + 2'd1;
						dec_cp = cp;
					end else begin
						dec_mode = jsu_pkg::MODE_TEXT;
						dec_digits = 2'd0;
						dec_cp = 16'h0000;
						// utf-8 encode, no surrogate pairing
						if (cp < 16'h0080) begin
							push_word(cp[7:0], jsu_pkg::ST_DATA, 1'b1);
						end else if (cp < 16'h0800) begin
							push_word({3'b110, cp[10:6]}, jsu_pkg::ST_DATA, 1'b0);
							push_word({2'b10, cp[5:0]}, jsu_pkg::ST_DATA, 1'b1);
						end else begin
							push_word({4'b1110, cp[15:12]}, jsu_pkg::ST_DATA, 1'b0);
							push_word({2'b10, cp[11:6]}, jsu_pkg::ST_DATA, 1'b0);
							push_word({2'b10, cp[5:0]}, jsu_pkg::ST_DATA, 1'b1);
						end
					end
				end
			end
		endcase
	endtask

	// driver: one word per handshake, payload held while stalled
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_byte <= 8'h00;
		end else begin
			if (in_valid && !in_stall) predict_unescape(in_byte);
			if (!in_valid || !in_stall) begin
				if (text_q.size() > 0 && !roll(in_idle_pct)) begin
					in_valid <= 1'b1;
					in_byte <= text_q.pop_front();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// monitor: check each accepted output word against the oldest prediction
	always @(posedge clk or negedge arst_n) begin
		out_word_t w;
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				if (decoded_q.size() == 0) begin
					$display("%0t: unexpected word out_byte=%02h status=%0d last_of_run=%0b",
						$time, out_byte, status, last_of_run);
					errors++;
				end else begin
					w = decoded_q.pop_front();
					if (out_byte !== w.data) begin
						$display("%0t: out_byte expected %02h actual %02h", $time, w.data, out_byte);
						errors++;
					end
					if (status !== w.st) begin
						$display("%0t: status expected %0d actual %0d", $time, w.st, status);
						errors++;
					end
					if (last_of_run !== w.last) begin
						$display("%0t: last_of_run expected %0b actual %0b",
							$time, w.last, last_of_run);
						errors++;
					end
				end
			end
			out_stall <= roll(out_stall_pct);
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT_CYCLES) begin
			$display("tb_json_string_unescaper_top NOT OK");
			$finish;
		end
	end

	task automatic send(input logic [7:0] b);
		text_q.push_back(b);
	endtask

	task automatic send_unicode(input logic [15:0] cp);
		send(jsu_pkg::CH_BSLASH);
		send(jsu_pkg::CH_U);
		send(hex_char(cp[15:12]));
		send(hex_char(cp[11:8]));
		send(hex_char(cp[7:4]));
		send(hex_char(cp[3:0]));
	endtask

	// one character of string content, escapes included
	task automatic send_content();
		logic [7:0] b;
		logic [15:0] cp;
		case ($urandom_range(9))
			0, 1, 2, 3: begin
				b = 8'($urandom_range(CH_SPACE, CH_TILDE));
				while (b == jsu_pkg::CH_QUOTE || b == jsu_pkg::CH_BSLASH)
					b = 8'($urandom_range(CH_SPACE, CH_TILDE));
				send(b);
			end
			4: send(8'($urandom_range(8'h80, 8'hFF)));
			5: begin
				b = 8'($urandom_range(1, 8'h1F));
				while (is_raw_ctrl(b)) b = 8'($urandom_range(1, 8'h1F));
				send(b);
			end
			6, 7: begin
				send(jsu_pkg::CH_BSLASH);
				send(esc_letter($urandom_range(7)));
			end
			default: begin
				case ($urandom_range(4))
					0: cp = 16'($urandom_range(0, 16'h007F));
					1: cp = 16'($urandom_range(16'h0080, 16'h07FF));
					2: cp = 16'($urandom_range(16'hD800, 16'hDFFF));
					3: cp = roll(50) ? 16'h0000 : 16'hFFFF;
					default: cp = 16'($urandom_range(16'h0800, 16'hFFFF));
				endcase
				send_unicode(cp);
			end
		endcase
	endtask

	// a string that ends in an error instead of a closing quote
	task automatic send_broken();
		logic [7:0] b;
		int k;
		case ($urandom_range(4))
			0: begin
				case ($urandom_range(4))
					0: send(jsu_pkg::CH_LF);
					1: send(jsu_pkg::CH_CR);
					2: send(jsu_pkg::CH_TAB);
					3: send(jsu_pkg::CH_BS);
					default: send(jsu_pkg::CH_FF);
				endcase
			end
			1: begin
				send(jsu_pkg::CH_BSLASH);
				b = 8'($urandom_range(1, 255));
				while (b == jsu_pkg::CH_QUOTE || b == jsu_pkg::CH_BSLASH
					|| b == jsu_pkg::CH_SLASH || b == jsu_pkg::CH_B
					|| b == jsu_pkg::CH_F || b == jsu_pkg::CH_N
					|| b == jsu_pkg::CH_R || b == jsu_pkg::CH_T
					|| b == jsu_pkg::CH_U)
					b = 8'($urandom_range(1, 255));
				send(b);
			end
			2, 3: begin
				send(jsu_pkg::CH_BSLASH);
				send(jsu_pkg::CH_U);
				for (k = $urandom_range(3); k > 0; k--) send(hex_char(4'($urandom_range(15))));
				b = 8'($urandom_range(1, 255));
				while (hex_val(b) >= 0) b = 8'($urandom_range(1, 255));
				send(b);
			end
			default: begin
				// end of text in plain content, after a backslash or among hex digits
				case ($urandom_range(2))
					1: send(jsu_pkg::CH_BSLASH);
					2: begin
						send(jsu_pkg::CH_BSLASH);
						send(jsu_pkg::CH_U);
						for (k = $urandom_range(3); k > 0; k--)
							send(hex_char(4'($urandom_range(15))));
					end
					default: ;
				endcase
				send(jsu_pkg::CH_NUL);
			end
		endcase
	endtask

	task automatic wait_drained();
		@(negedge clk);
		while (text_q.size() > 0 || in_valid || decoded_q.size() > 0) @(negedge clk);
	endtask

	initial begin
		int phase;
		int k;
		int start_len;
		int sent;

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: noise before a quote, byte extremes, unicode edges, each error kind
		send(jsu_pkg::CH_NUL);
		send(8'hFF);
		send(jsu_pkg::CH_QUOTE);
		send(8'h80);
		send_unicode(16'h0000);
		send_unicode(16'hD80F);
		send(jsu_pkg::CH_BSLASH);
		send(8'h71);
		send(jsu_pkg::CH_QUOTE);
		send(jsu_pkg::CH_BSLASH);
		send(jsu_pkg::CH_U);
		send(8'h37);
		send(8'h67);
		send(jsu_pkg::CH_QUOTE);
		send(jsu_pkg::CH_TAB);
		send(jsu_pkg::CH_QUOTE);
		send(jsu_pkg::CH_NUL);
		wait_drained();

		for (phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin in_idle_pct = 0; out_stall_pct = 0; end
				1: begin in_idle_pct = 59; out_stall_pct = 0; end
				2: begin in_idle_pct = 0; out_stall_pct = 59; end
				default: begin in_idle_pct = 11; out_stall_pct = 11; end
			endcase
			sent = 0;
			while (sent < RAND_PER_PHASE) begin
				start_len = text_q.size();
				k = $urandom_range(99);
				if (k < 10) begin
					send(8'($urandom_range(255)));
				end else begin
					send(jsu_pkg::CH_QUOTE);
					for (k = $urandom_range(6); k > 0; k--) send_content();
					if (roll(15)) send_broken();
					else send(jsu_pkg::CH_QUOTE);
				end
				sent += text_q.size() - start_len;
			end
			// hold the sender until the decoder has fully drained
			wait_drained();
		end

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0) begin
			$display("tb_json_string_unescaper_top OK");
		end else begin
			$display("tb_json_string_unescaper_top NOT OK");
		end
		$finish;
	end

endmodule
